@@ src/assert_macros.svh @@
// Assertion macros shared by the frame receiver RTL.
// Included by modules that check their own control logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CRSF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define CRSF_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ src/crsf_pkg.sv @@
// Shared constants, codes and interface structs of the frame receiver.
// No dependencies; imported by every module of the block but the generic RAM.
`default_nettype none

package crsf_pkg;

   localparam int PAYLOAD_BYTES = 64;
   localparam int PAY_AW = $clog2(PAYLOAD_BYTES);
   localparam logic [8:0] PAYLOAD_LIMIT = 9'(PAYLOAD_BYTES);

   localparam logic [7:0] MIN_LENGTH = 8'd4;
   localparam logic [7:0] DEFAULT_LENGTH = 8'd5;

   localparam logic [4:0] CHANNEL_BITS = 5'd11;
   localparam logic [4:0] LINK_BITS = 5'd8;
   localparam logic [3:0] LAST_CHANNEL = 4'd15;
   localparam logic [3:0] LAST_LINK_BYTE = 4'd9;

   localparam logic [7:0] RST_SYNC_BYTE = 8'd200;
   localparam logic [15:0] RST_MIN_GAP = 16'd500;
   localparam logic [5:0] RST_MAX_LENGTH = 6'd62;
   localparam logic [7:0] RST_RC_TYPE = 8'd22;
   localparam logic [7:0] RST_LINK_TYPE = 8'd20;

   typedef enum logic [2:0] {
      CSR_SYNC_BYTE = 3'd0,
      CSR_MIN_GAP   = 3'd1,
      CSR_MAX_LEN   = 3'd2,
      CSR_RC_TYPE   = 3'd3,
      CSR_LINK_TYPE = 3'd4
   } crsf_csr_type;

   typedef enum logic {
      JOB_RC   = 1'b0,
      JOB_LINK = 1'b1
   } crsf_job_type;

   typedef struct packed {
      logic              we;
      logic [PAY_AW-1:0] addr;
      logic [7:0]        data;
   } crsf_store_wr_type;

   typedef struct packed {
      logic         push;
      crsf_job_type kind;
   } crsf_job_req_type;

   typedef struct packed {
      logic busy;
      logic q_empty;
      logic q_full;
   } crsf_back_status_type;

endpackage

`default_nettype wire

@@ src/crsf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module crsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ src/crsf_front.sv @@
// Front part: configuration registers, byte counting, frame classification.
// Depends on crsf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module crsf_front import crsf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [7:0]           rx_byte,
   input  logic [15:0]          gap_us,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_wdata,
   input  crsf_back_status_type back_status,
   output crsf_store_wr_type    store_wr,
   output crsf_job_req_type     job_req
);

   logic [7:0]  sync_ff, sync_in;
   logic [15:0] min_gap_ff, min_gap_in;
   logic [5:0]  max_ff, max_in;
   logic [7:0]  rc_type_ff, rc_type_in;
   logic [7:0]  link_type_ff, link_type_in;

   logic        in_sync_ff, in_sync_in;
   logic [6:0]  count_ff, count_in;
   logic [7:0]  flen_ff, flen_in;
   logic [7:0]  kind_ff, kind_in;

   logic        may_write;
   logic        accept;

   assign may_write = in_sync_ff && (count_ff >= 7'd3);
   assign full = (may_write && (back_status.busy || !back_status.q_empty))
                 || back_status.q_full;
   assign accept = push && !full;

   always_comb begin
      sync_in = sync_ff;
      min_gap_in = min_gap_ff;
      max_in = max_ff;
      rc_type_in = rc_type_ff;
      link_type_in = link_type_ff;
      if (csr_we) begin
         unique case (crsf_csr_type'(csr_index))
            CSR_SYNC_BYTE: sync_in = csr_wdata[7:0];
            CSR_MIN_GAP:   min_gap_in = csr_wdata;
            CSR_MAX_LEN:   max_in = csr_wdata[5:0];
            CSR_RC_TYPE:   rc_type_in = csr_wdata[7:0];
            CSR_LINK_TYPE: link_type_in = csr_wdata[7:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      logic       start;
      logic       sync0;
      logic       sync1;
      logic [6:0] cnt0;
      logic [6:0] cnt1;
      logic [6:0] cnt2;
      logic [6:0] pos;
      logic [8:0] pos9;
      logic       done;

      start = (gap_us > min_gap_ff) && (rx_byte == sync_ff);
      cnt0 = start ? 7'd0 : count_ff;
      sync0 = start || in_sync_ff;
      cnt1 = cnt0;
      sync1 = sync0;
      cnt2 = cnt0;
      pos = 7'd0;
      pos9 = 9'd0;
      done = 1'b0;
      count_in = count_ff;
      in_sync_in = in_sync_ff;
      flen_in = flen_ff;
      kind_in = kind_ff;
      store_wr = '0;
      job_req = '0;

      if (accept && sync0) begin
         if (cnt0 == 7'd0) begin
            flen_in = DEFAULT_LENGTH;
         end
         if (cnt0 == 7'd1) begin
            if ((rx_byte > {2'b00, max_ff}) || (rx_byte < MIN_LENGTH)) begin
               sync1 = 1'b0;
               cnt1 = 7'd0;
            end else begin
               flen_in = rx_byte;
            end
         end
         if (cnt0 == 7'd2) begin
            kind_in = rx_byte;
         end
         if ((cnt1 < {1'b0, max_ff}) && (cnt1 > 7'd2)) begin
            pos = cnt1 - 7'd3;
            pos9 = {2'b00, pos};
            store_wr.we = pos9 < PAYLOAD_LIMIT;
            store_wr.addr = pos9[PAY_AW-1:0];
            store_wr.data = rx_byte;
         end else if (cnt1 > {1'b0, max_ff}) begin
            cnt1 = 7'd0;
            sync1 = 1'b0;
         end
         cnt2 = cnt1 + 7'd1;
         done = sync1 && ({2'b00, cnt2} == ({1'b0, flen_in} + 9'd2));
         if (done) begin
            count_in = 7'd0;
            in_sync_in = 1'b0;
            if (kind_in == rc_type_ff) begin
               job_req.push = 1'b1;
               job_req.kind = JOB_RC;
            end else if (kind_in == link_type_ff) begin
               job_req.push = 1'b1;
               job_req.kind = JOB_LINK;
            end
         end else begin
            count_in = cnt2;
            in_sync_in = sync1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= RST_SYNC_BYTE;
         min_gap_ff <= RST_MIN_GAP;
         max_ff <= RST_MAX_LENGTH;
         rc_type_ff <= RST_RC_TYPE;
         link_type_ff <= RST_LINK_TYPE;
         in_sync_ff <= 1'b0;
         count_ff <= 7'd0;
         flen_ff <= DEFAULT_LENGTH;
         kind_ff <= 8'd0;
      end else begin
         sync_ff <= sync_in;
         min_gap_ff <= min_gap_in;
         max_ff <= max_in;
         rc_type_ff <= rc_type_in;
         link_type_ff <= link_type_in;
         in_sync_ff <= in_sync_in;
         count_ff <= count_in;
         flen_ff <= flen_in;
         kind_ff <= kind_in;
      end
   end

   `CRSF_NEVER(a_no_write_while_read, clock, reset,
      store_wr.we && (back_status.busy || !back_status.q_empty),
      "payload write while a frame is being read out")
   `CRSF_NEVER(a_no_push_when_full, clock, reset, job_req.push && back_status.q_full,
      "job pushed into full queue")
   `CRSF_ASSERT(a_count_bound, clock, reset, count_ff <= 7'd64,
      "byte count beyond frame limit")

endmodule

`default_nettype wire

@@ src/crsf_job_queue.sv @@
// Two-entry queue of frame jobs between the front and back parts.
// Depends on crsf_pkg.
`default_nettype none

module crsf_job_queue import crsf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  crsf_job_req_type job_req,
   input  logic             pop,
   output crsf_job_type     head,
   output logic             q_empty,
   output logic             q_full
);

   crsf_job_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   fill_ff, fill_in;
   logic         do_push;
   logic         do_pop;

   assign q_empty = (fill_ff == 2'd0);
   assign q_full = (fill_ff == 2'd2);
   assign head = entry_ff[rd_ptr_ff];
   assign do_push = job_req.push && !q_full;
   assign do_pop = pop && !q_empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= job_req.kind;
      end
   end

endmodule

`default_nettype wire

@@ src/crsf_back.sv @@
// Back part: reads the payload store and unpacks channels or statistics bytes
// into the result register. Depends on crsf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module crsf_back import crsf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  crsf_job_type      q_head,
   output logic              q_pop,
   output logic              rd_en,
   output logic [PAY_AW-1:0] rd_addr,
   input  logic [7:0]        rd_byte,
   output logic              busy,
   input  logic              pop,
   output logic              empty,
   output logic              rsp_kind,
   output logic [3:0]        rsp_index,
   output logic [10:0]       rsp_value,
   output logic              rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_EMIT
   } state_type;

   state_type    state_ff;
   crsf_job_type kind_ff;
   logic [4:0]   ptr_ff;
   logic [17:0]  bits_ff;
   logic [4:0]   nbits_ff;
   logic [3:0]   idx_ff;
   logic         out_valid_ff;
   logic         out_kind_ff;
   logic [3:0]   out_index_ff;
   logic [10:0]  out_value_ff;
   logic         out_last_ff;

   logic         is_link;
   logic [4:0]   need;
   logic [3:0]   last_idx;
   logic         slot_free;
   logic         emit_fire;
   logic [10:0]  emit_value;
   logic [17:0]  bits_shifted;
   logic [17:0]  bits_loaded;

   assign is_link = (kind_ff == JOB_LINK);
   assign need = is_link ? LINK_BITS : CHANNEL_BITS;
   assign last_idx = is_link ? LAST_LINK_BYTE : LAST_CHANNEL;
   assign slot_free = !out_valid_ff || pop;
   assign emit_fire = (state_ff == ST_EMIT) && (nbits_ff >= need) && slot_free;
   assign emit_value = is_link ? {3'b000, bits_ff[7:0]} : bits_ff[10:0];
   assign bits_shifted = is_link ? (bits_ff >> 8) : (bits_ff >> 11);
   assign bits_loaded = bits_ff | ({10'd0, rd_byte} << nbits_ff);

   assign q_pop = (state_ff == ST_IDLE) && !q_empty;
   assign rd_en = (state_ff == ST_FETCH);
   assign rd_addr = PAY_AW'(ptr_ff);
   assign busy = (state_ff != ST_IDLE);

   assign empty = !out_valid_ff;
   assign rsp_kind = out_kind_ff;
   assign rsp_index = out_index_ff;
   assign rsp_value = out_value_ff;
   assign rsp_last = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         nbits_ff <= 5'd0;
      end else begin
         if (emit_fire) begin
            out_valid_ff <= 1'b1;
         end else if (pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  kind_ff <= q_head;
                  ptr_ff <= 5'd0;
                  bits_ff <= 18'd0;
                  nbits_ff <= 5'd0;
                  idx_ff <= 4'd0;
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               bits_ff <= bits_loaded;
               nbits_ff <= nbits_ff + LINK_BITS;
               ptr_ff <= ptr_ff + 5'd1;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (nbits_ff >= need) begin
                  if (slot_free) begin
                     out_kind_ff <= kind_ff;
                     out_index_ff <= idx_ff;
                     out_value_ff <= emit_value;
                     out_last_ff <= (idx_ff == last_idx);
                     bits_ff <= bits_shifted;
                     nbits_ff <= nbits_ff - need;
                     idx_ff <= idx_ff + 4'd1;
                     if (idx_ff == last_idx) begin
                        state_ff <= ST_IDLE;
                     end
                  end
               end else begin
                  state_ff <= ST_FETCH;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `CRSF_ASSERT(a_bit_window, clock, reset, nbits_ff <= 5'd18,
      "bit window overflow")
   `CRSF_ASSERT(a_load_after_fetch, clock, reset,
      (state_ff == ST_LOAD) |-> ($past(state_ff) == ST_FETCH),
      "load without a preceding fetch")
   `CRSF_ASSERT(a_last_index, clock, reset,
      (out_valid_ff && out_last_ff) |->
         (out_index_ff == (out_kind_ff ? LAST_LINK_BYTE : LAST_CHANNEL)),
      "last flag on wrong index")

endmodule

`default_nettype wire

@@ src/crsf_frame_receiver_unit.sv @@
// Frame receiver top level: front, job queue, payload store, back.
// An RC frame gives 16 results and a link statistics frame 10; the back part reads
// them from the store through its one-byte-per-read port, and payload bytes stall meanwhile.
// Synchronous reset; the store reads as zero after reset through per-byte valid bits.
`default_nettype none

module crsf_frame_receiver_unit import crsf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   input  logic [15:0] req_gap_us,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_kind,
   output logic [3:0]  rsp_index,
   output logic [10:0] rsp_value,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   crsf_store_wr_type    store_wr;
   crsf_job_req_type     job_req;
   crsf_back_status_type back_status;
   crsf_job_type         q_head;
   logic                 q_empty;
   logic                 q_full;
   logic                 q_pop;
   logic                 back_busy;
   logic                 rd_en;
   logic [PAY_AW-1:0]    rd_addr;
   logic [7:0]           ram_q;
   logic [7:0]           rd_byte;
   logic [PAYLOAD_BYTES-1:0] valid_ff;
   logic                 rd_valid_ff;

   assign back_status.busy = back_busy;
   assign back_status.q_empty = q_empty;
   assign back_status.q_full = q_full;

   crsf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .rx_byte     (req_rx_byte),
      .gap_us      (req_gap_us),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .back_status (back_status),
      .store_wr    (store_wr),
      .job_req     (job_req)
   );

   crsf_job_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .job_req (job_req),
      .pop     (q_pop),
      .head    (q_head),
      .q_empty (q_empty),
      .q_full  (q_full)
   );

   crsf_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_BYTES)
   ) u_store (
      .clock (clock),
      .we    (store_wr.we),
      .waddr (store_wr.addr),
      .wdata (store_wr.data),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (store_wr.we) begin
            valid_ff[store_wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_byte = ram_q & {8{rd_valid_ff}};

   crsf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_byte   (rd_byte),
      .busy      (back_busy),
      .pop       (pop),
      .empty     (empty),
      .rsp_kind  (rsp_kind),
      .rsp_index (rsp_index),
      .rsp_value (rsp_value),
      .rsp_last  (rsp_last)
   );

endmodule

`default_nettype wire

@@ test/crsf_frame_checker.sv @@
// Checker for the frame receiver: tracks register writes and accepted bytes,
// decodes frames on its own and compares each result transfer in order.
// Depends on crsf_pkg for register codes, result kinds and frame constants.
module crsf_frame_checker import crsf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [7:0]  req_rx_byte,
   input  logic [15:0] req_gap_us,
   input  logic        empty,
   input  logic        pop,
   input  logic        rsp_kind,
   input  logic [3:0]  rsp_index,
   input  logic [10:0] rsp_value,
   input  logic        rsp_last,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatches,
   output int          fields_waiting,
   output int          fields_seen
);

   typedef struct packed {
      crsf_job_type kind;
      logic [3:0]   index;
      logic [10:0]  value;
      logic         last;
   } frame_field_type;

   frame_field_type decoded_q[$];

   logic [7:0]  sync_code;
   logic [15:0] gap_floor;
   logic [5:0]  len_cap;
   logic [7:0]  rc_code;
   logic [7:0]  link_code;

   logic        synced;
   logic [6:0]  byte_cnt;
   logic [7:0]  frame_len;
   logic [7:0]  frame_type;
   logic [7:0]  payload [PAYLOAD_BYTES];

   function automatic logic [10:0] chan_value(int c);
      logic [10:0] v;
      int p;
      for (int b = 0; b < int'(CHANNEL_BITS); b++) begin
         p = c * int'(CHANNEL_BITS) + b;
         v[b] = (p / 8 < PAYLOAD_BYTES) ? payload[p / 8][p % 8] : 1'b0;
      end
      return v;
   endfunction

   task automatic decode_byte(input logic [7:0] rx, input logic [15:0] gap);
      int cnt;
      cnt = int'(byte_cnt);
      if (gap > gap_floor && rx == sync_code) begin
         cnt = 0;
         synced = 1'b1;
      end
      if (synced) begin
         if (cnt < 1)
            frame_len = DEFAULT_LENGTH;
         if (cnt == 1) begin
            if (rx > len_cap || rx < MIN_LENGTH) begin
               synced = 1'b0;
               cnt = 0;
            end else begin
               frame_len = rx;
            end
         end
         if (cnt == 2)
            frame_type = rx;
         if (cnt < int'(len_cap) && cnt > 2) begin
            if (cnt - 3 < PAYLOAD_BYTES)
               payload[cnt - 3] = rx;
         end else if (cnt > int'(len_cap)) begin
            cnt = 0;
            synced = 1'b0;
         end
         cnt = (cnt + 1) % 128;
      end
      if (synced && cnt == int'(frame_len) + 2) begin
         cnt = 0;
         synced = 1'b0;
         if (frame_type == rc_code) begin
            for (int c = 0; c <= int'(LAST_CHANNEL); c++)
               decoded_q.push_back(frame_field_type'{JOB_RC, 4'(c), chan_value(c),
                                                     c == int'(LAST_CHANNEL)});
         end else if (frame_type == link_code) begin
            for (int k = 0; k <= int'(LAST_LINK_BYTE); k++)
               decoded_q.push_back(frame_field_type'{JOB_LINK, 4'(k), {3'b000, payload[k]},
                                                     k == int'(LAST_LINK_BYTE)});
         end
      end
      byte_cnt = 7'(cnt);
   endtask

   task automatic check_field();
      frame_field_type want;
      fields_seen++;
      if (decoded_q.size() == 0) begin
         $error("result with nothing expected: kind=%0d index=%0d value=%0d last=%0d",
                rsp_kind, rsp_index, rsp_value, rsp_last);
         mismatches++;
         return;
      end
      want = decoded_q.pop_front();
      if (rsp_kind !== want.kind) begin
         $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
         mismatches++;
      end
      if (rsp_index !== want.index) begin
         $error("index: expected %0d, got %0d", want.index, rsp_index);
         mismatches++;
      end
      if (rsp_value !== want.value) begin
         $error("value: expected %0d, got %0d", want.value, rsp_value);
         mismatches++;
      end
      if (rsp_last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, rsp_last);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sync_code = RST_SYNC_BYTE;
         gap_floor = RST_MIN_GAP;
         len_cap = RST_MAX_LENGTH;
         rc_code = RST_RC_TYPE;
         link_code = RST_LINK_TYPE;
         synced = 1'b0;
         byte_cnt = '0;
         frame_len = DEFAULT_LENGTH;
         frame_type = '0;
         for (int i = 0; i < PAYLOAD_BYTES; i++)
            payload[i] = '0;
         decoded_q.delete();
         mismatches = 0;
         fields_seen = 0;
      end else begin
         if (pop && !empty)
            check_field();
         if (csr_we) begin
            case (csr_index)
               CSR_SYNC_BYTE: sync_code = csr_wdata[7:0];
               CSR_MIN_GAP:   gap_floor = csr_wdata;
               CSR_MAX_LEN:   len_cap = csr_wdata[5:0];
               CSR_RC_TYPE:   rc_code = csr_wdata[7:0];
               CSR_LINK_TYPE: link_code = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (push && !full)
            decode_byte(req_rx_byte, req_gap_us);
      end
      fields_waiting = decoded_q.size();
   end

endmodule

@@ test/testbench.sv @@
// Top of the frame receiver testbench: clock, reset, byte and frame stimulus,
// result drain and verdict. Depends on crsf_pkg, the receiver RTL and
// crsf_frame_checker, which predicts and compares every result transfer.
module testbench import crsf_pkg::*; ();

   localparam int HOLD_CYCLES = 2500;
   localparam int SETTLE_CYCLES = 150;

   logic        clock = 1'b0;
   logic        reset;
   logic        push;
   logic        full;
   logic [7:0]  req_rx_byte;
   logic [15:0] req_gap_us;
   logic        empty;
   logic        pop;
   logic        rsp_kind;
   logic [3:0]  rsp_index;
   logic [10:0] rsp_value;
   logic        rsp_last;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   int mismatches;
   int fields_waiting;
   int fields_seen;

   logic [7:0]  sync_code = RST_SYNC_BYTE;
   logic [15:0] gap_floor = RST_MIN_GAP;
   int          len_cap = int'(RST_MAX_LENGTH);
   logic [7:0]  rc_code = RST_RC_TYPE;
   logic [7:0]  link_code = RST_LINK_TYPE;

   int bytes_sent = 0;
   int frames_started = 0;
   int settings_used = 1;
   int tx_stretch = 0;
   bit tx_calm = 1'b0;

   crsf_frame_receiver_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_rx_byte (req_rx_byte),
      .req_gap_us  (req_gap_us),
      .empty       (empty),
      .pop         (pop),
      .rsp_kind    (rsp_kind),
      .rsp_index   (rsp_index),
      .rsp_value   (rsp_value),
      .rsp_last    (rsp_last),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   crsf_frame_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_rx_byte    (req_rx_byte),
      .req_gap_us     (req_gap_us),
      .empty          (empty),
      .pop            (pop),
      .rsp_kind       (rsp_kind),
      .rsp_index      (rsp_index),
      .rsp_value      (rsp_value),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .fields_waiting (fields_waiting),
      .fields_seen    (fields_seen)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   // idle length per transfer, with occasional stretches of back-to-back transfers
   function automatic int pause_len(inout int stretch, inout bit calm);
      if (stretch == 0) begin
         stretch = $urandom_range(10, 60);
         calm = ($urandom_range(0, 3) == 0);
      end
      stretch--;
      return calm ? 0 : $urandom_range(0, 14);
   endfunction

   function automatic logic [15:0] start_gap();
      if (gap_floor == 16'hFFFF)
         return 16'hFFFF;
      return 16'($urandom_range(int'(gap_floor) + 1, 65535));
   endfunction

   function automatic logic [15:0] inner_gap();
      return 16'($urandom_range(0, int'(gap_floor)));
   endfunction

   function automatic int good_len();
      return (len_cap > 4) ? $urandom_range(4, len_cap - 1) : 4;
   endfunction

   task automatic put_byte(input logic [7:0] b, input logic [15:0] g);
      int w;
      w = pause_len(tx_stretch, tx_calm);
      if (w > 0) begin
         push <= 1'b0;
         repeat (w) @(negedge clock);
      end
      req_rx_byte <= b;
      req_gap_us <= g;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // sync, length and type, then body bytes (length-1 of them completes the frame)
   task automatic send_frame(input logic [7:0] ftype, input int len, input int body);
      frames_started++;
      put_byte(sync_code, start_gap());
      put_byte(8'(len), inner_gap());
      put_byte(ftype, inner_gap());
      repeat (body) put_byte(8'($urandom), inner_gap());
   endtask

   task automatic drain();
      push <= 1'b0;
      while (fields_waiting != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] sb, input logic [15:0] gap,
                                 input int len, input logic [7:0] rc, input logic [7:0] lk);
      drain();
      write_reg(CSR_SYNC_BYTE, {8'h00, sb});
      write_reg(CSR_MIN_GAP, gap);
      write_reg(CSR_MAX_LEN, 16'(len));
      write_reg(CSR_RC_TYPE, {8'h00, rc});
      write_reg(CSR_LINK_TYPE, {8'h00, lk});
      // unused indexes must leave every register alone
      for (int i = int'(CSR_LINK_TYPE) + 1; i < (1 << $bits(csr_index)); i++)
         write_reg(3'(i), 16'($urandom));
      csr_we <= 1'b0;
      sync_code = sb;
      gap_floor = gap;
      len_cap = len;
      rc_code = rc;
      link_code = lk;
      settings_used++;
   endtask

   task automatic random_traffic(input int n);
      int target;
      int pick;
      int len;
      target = bytes_sent + n;
      while (bytes_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            len = (len_cap > 24) ? 24 : good_len();
            send_frame(rc_code, len, len - 1);
         end else if (pick < 50) begin
            len = (len_cap > 12) ? $urandom_range(12, len_cap - 1) : good_len();
            send_frame(link_code, len, len - 1);
         end else if (pick < 62) begin
            len = good_len();
            send_frame(8'($urandom), len, len - 1);
         end else if (pick < 70) begin
            send_frame(rc_code, len_cap, len_cap - 1 + int'($urandom_range(0, 2)));
         end else if (pick < 80) begin
            len = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(len_cap + 1, 255);
            send_frame($urandom_range(0, 1) ? rc_code : link_code, len, $urandom_range(0, 5));
         end else if (pick < 92) begin
            len = good_len();
            send_frame($urandom_range(0, 1) ? rc_code : link_code, len,
                       $urandom_range(0, len - 2));
         end else begin
            repeat ($urandom_range(1, 6))
               put_byte($urandom_range(0, 2) == 0 ? sync_code : 8'($urandom), 16'($urandom));
         end
      end
   endtask

   // result side; one long hold-off lets the receiver fill and stall its input
   initial begin
      int w;
      int stretch;
      bit calm;
      int pops;
      bit held;
      pop = 1'b0;
      stretch = 0;
      calm = 1'b0;
      pops = 0;
      held = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (pops == 30 && !held) begin
            held = 1'b1;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         w = pause_len(stretch, calm);
         if (w > 0) begin
            pop <= 1'b0;
            repeat (w) @(negedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         pops++;
         @(negedge clock);
      end
   end

   initial begin
      logic [7:0] link_body [11];
      reset = 1'b1;
      push = 1'b0;
      req_rx_byte = '0;
      req_gap_us = '0;
      csr_we = 1'b0;
      csr_index = CSR_SYNC_BYTE;
      csr_wdata = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sync without enough gap, bad lengths, a full link frame, a restart mid-frame
      put_byte(RST_SYNC_BYTE, RST_MIN_GAP);
      put_byte(RST_SYNC_BYTE, 16'hFFFF);
      put_byte(8'd3, 16'h0000);
      put_byte(RST_SYNC_BYTE, RST_MIN_GAP + 16'd1);
      put_byte(8'd255, 16'h0000);
      put_byte(RST_SYNC_BYTE, 16'hFFFF);
      put_byte(8'd12, 16'h0000);
      put_byte(RST_LINK_TYPE, 16'd1);
      link_body = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, RST_SYNC_BYTE, 8'hFF, 8'hAA,
                    8'h55, 8'h00};
      foreach (link_body[i])
         put_byte(link_body[i], RST_MIN_GAP);
      put_byte(RST_SYNC_BYTE, 16'hFFFF);
      put_byte(8'd24, 16'h0000);
      put_byte(RST_RC_TYPE, 16'h0000);
      put_byte(RST_SYNC_BYTE, 16'd501);
      put_byte(8'd4, 16'h0000);
      frames_started += 5;

      apply_settings(8'hEE, 16'd0, 62, 8'd22, 8'd20);
      random_traffic(120);
      apply_settings(8'h00, 16'd65534, 4, 8'hFF, 8'hFF);
      random_traffic(25);
      apply_settings(8'hFF, 16'hFFFF, 5, 8'h00, 8'h00);
      random_traffic(12);
      apply_settings(8'hFF, 16'd1000, 5, 8'h55, 8'h55);
      random_traffic(40);
      begin
         logic [7:0] rc;
         rc = 8'($urandom);
         apply_settings(8'($urandom), 16'($urandom_range(1, 2000)), $urandom_range(26, 61),
                        rc, rc ^ 8'($urandom_range(1, 255)));
      end
      random_traffic(105);
      apply_settings(RST_SYNC_BYTE, RST_MIN_GAP, 25, 8'h00, 8'hFF);
      random_traffic(90);

      drain();
      $display("Sent %0d bytes with %0d frame starts across %0d register settings.",
               bytes_sent, frames_started, settings_used);
      $display("Checked %0d result transfers, including a %0d-cycle result hold-off.",
               fields_seen, HOLD_CYCLES);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/crsf_pkg.sv
src/crsf_ram.sv
src/crsf_front.sv
src/crsf_job_queue.sv
src/crsf_back.sv
src/crsf_frame_receiver_unit.sv
test/crsf_frame_checker.sv
test/testbench.sv
